>>> sv/pcpx_pkg.sv
// ----------------------------------------------------------------------------
// pcpx_pkg
// Shared types and constants of the PNG chunk payload XOR block.
// ----------------------------------------------------------------------------
package pcpx_pkg;

  localparam int ByteW         = 8;
  localparam int CntW          = 31;
  localparam int ApbAddrW      = 3;
  localparam int ApbDataW      = 32;
  localparam int QueueDepthDef = 2;

  localparam logic [ByteW-1:0] KeyReset  = 8'd232;
  localparam logic [31:0]      TypeIdat  = 32'h4944_4154;
  localparam logic [31:0]      TypeIend  = 32'h4945_4E44;

  // register word index, taken from paddr[2]
  localparam logic RegXorKey = 1'b0;

  typedef enum logic [2:0] {
    PhSig  = 3'd0,
    PhLen  = 3'd1,
    PhType = 3'd2,
    PhData = 3'd3,
    PhCrc  = 3'd4,
    PhEnd  = 3'd5,
    PhErr  = 3'd6
  } phase_e;

  // classified byte handed from the parser to the output side
  typedef struct packed {
    logic [ByteW-1:0] data;
    phase_e           phase;
    logic             flip;
  } entry_t;

  function automatic logic [ByteW-1:0] sig_byte(input logic [2:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

endpackage

>>> sv/pcpx_ifs.sv
// ----------------------------------------------------------------------------
// pcpx channel interfaces
// Valid/ready byte input channel and classified byte output channel.
// ----------------------------------------------------------------------------
interface pcpx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pcpx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_phase;
  logic       was_changed;

  modport source (output valid, output out_byte, output byte_phase, output was_changed,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_phase, input was_changed,
                  output ready);
endinterface

>>> sv/pcpx_front.sv
// ----------------------------------------------------------------------------
// pcpx_front
// Chunk walker: tracks signature, length, type, payload and CRC fields and
// tags every accepted byte with its phase and whether it gets XORed.
// ----------------------------------------------------------------------------
module pcpx_front import pcpx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] byte_i,
  output entry_t           entry_o
);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] len_q, len_d;
  // first length byte has bit 7 clear, so 23 bits hold the first three bytes
  logic [22:0]     shift_q, shift_d;
  logic [23:0]     type_q, type_d;
  logic            idat_q, idat_d;

  phase_e          rep;
  logic            flip;
  logic [CntW-1:0] cnt_inc;
  logic [31:0]     type_word;

  assign cnt_inc   = cnt_q + 31'd1;
  assign type_word = {type_q, byte_i};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    shift_d = shift_q;
    type_d  = type_q;
    idat_d  = idat_q;
    rep     = phase_q;
    flip    = 1'b0;
    unique case (phase_q)
      PhSig: begin
        if (byte_i != sig_byte(cnt_q[2:0])) begin
          phase_d = PhErr;
          rep     = PhErr;
        end else if (cnt_q >= 31'd7) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PhLen;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhLen: begin
        if (cnt_q == '0 && byte_i[7]) begin
          phase_d = PhErr;
          rep     = PhErr;
        end else begin
          shift_d = {shift_q[14:0], byte_i};
          if (cnt_q >= 31'd3) begin
            len_d   = {shift_q[22:0], byte_i};
            cnt_d   = '0;
            type_d  = '0;
            phase_d = PhType;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      PhType: begin
        type_d = type_word[23:0];
        if (cnt_q >= 31'd3) begin
          cnt_d  = '0;
          idat_d = (type_word == TypeIdat);
          if (type_word == TypeIend) begin
            phase_d = PhEnd;
          end else if (len_q == '0) begin
            phase_d = PhCrc;
          end else begin
            phase_d = PhData;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhData: begin
        flip = idat_q;
        if (cnt_inc >= len_q) begin
          cnt_d   = '0;
          phase_d = PhCrc;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhCrc: begin
        if (cnt_q >= 31'd3) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PhLen;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhErr: rep = PhErr;
      PhEnd: rep = PhEnd;
      default: rep = PhEnd;
    endcase
  end

  assign entry_o.data  = byte_i;
  assign entry_o.phase = rep;
  assign entry_o.flip  = flip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSig;
      cnt_q   <= '0;
      len_q   <= '0;
      shift_q <= '0;
      type_q  <= '0;
      idat_q  <= 1'b0;
    end else if (push_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      shift_q <= shift_d;
      type_q  <= type_d;
      idat_q  <= idat_d;
    end
  end

endmodule

>>> sv/pcpx_queue.sv
// ----------------------------------------------------------------------------
// pcpx_queue
// Short FIFO of classified bytes between the chunk walker and output stage.
// ----------------------------------------------------------------------------
module pcpx_queue import pcpx_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wr_entry_i,
  input  logic   pop_i,
  output entry_t rd_entry_o,
  output logic   full_o,
  output logic   nonempty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);

  entry_t           mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (fill_q == FillW'(Depth));
  assign nonempty_o = (fill_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

>>> sv/pcpx_back.sv
// ----------------------------------------------------------------------------
// pcpx_back
// Output stage: applies the key to payload bytes and holds the result until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module pcpx_back import pcpx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  entry_t            entry_i,
  input  logic [ByteW-1:0]  key_i,
  output logic              pop_o,
  pcpx_out_if.source        out_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  phase_e           phase_q;
  logic             chg_q;

  assign pop_o = avail_i && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q  <= entry_i.flip ? (entry_i.data ^ key_i) : entry_i.data;
      phase_q <= entry_i.phase;
      chg_q   <= entry_i.flip;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.byte_phase  = phase_q;
  assign out_o.was_changed = chg_q;

endmodule

>>> sv/png_chunk_payload_xor_top.sv
// ----------------------------------------------------------------------------
// png_chunk_payload_xor_top
// Byte-serial PNG chunk walker that XORs IDAT payload bytes with a key.
// ----------------------------------------------------------------------------
// Takes one PNG file byte per clock while the queue has room and returns one
// classified byte per input byte, in order. The sustained rate is one byte per
// cycle while the output side takes bytes, set by the field walker, which
// updates on every accepted byte. An accepted byte is written into the queue
// and moves into the output register once that register is empty or being
// taken, so output valid is registered. The queue holds QueueDepth bytes, so
// the input keeps flowing while the output is stalled until the queue is full.
// The key register sits at APB address 0 (reset 232) and should be written
// only while no bytes are in flight.
// ----------------------------------------------------------------------------
module png_chunk_payload_xor_top import pcpx_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pcpx_in_if.sink             in_i,
  pcpx_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [ByteW-1:0] key_q;
  logic             push, pop, full, nonempty;
  entry_t           wr_entry, rd_entry;

  // register file: one key byte
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegXorKey) ? {{(ApbDataW-ByteW){1'b0}}, key_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
    end else if (psel && penable && pwrite && paddr[2] == RegXorKey) begin
      key_q <= pwdata[ByteW-1:0];
    end
  end

  assign in_i.ready = !full;
  assign push       = in_i.valid && !full;

  pcpx_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .byte_i  (in_i.in_byte),
    .entry_o (wr_entry)
  );

  pcpx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_entry_i (wr_entry),
    .pop_i      (pop),
    .rd_entry_o (rd_entry),
    .full_o     (full),
    .nonempty_o (nonempty)
  );

  pcpx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (nonempty),
    .entry_i (rd_entry),
    .key_i   (key_q),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> sv/pcpx_checker.sv
// ----------------------------------------------------------------------------
// pcpx_checker
// Port-level checks on the output channel of the chunk walker.
// ----------------------------------------------------------------------------
module pcpx_checker import pcpx_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [2:0] byte_phase_i,
  input logic       was_changed_i
);

  logic err_seen_q, end_seen_q;
  logic out_xfer;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      end_seen_q <= 1'b0;
    end else if (out_xfer) begin
      if (byte_phase_i == PhErr) err_seen_q <= 1'b1;
      if (byte_phase_i == PhEnd) end_seen_q <= 1'b1;
    end
  end

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(byte_phase_i) && $stable(was_changed_i))
    else $error("output transaction changed while stalled");

  // only payload bytes are ever XORed
  a_chg_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && was_changed_i |-> byte_phase_i == PhData)
    else $error("changed byte outside payload");

  // error is sticky until reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && err_seen_q |-> byte_phase_i == PhErr)
    else $error("byte after error not tagged as error");

  // after IEND every byte is tagged as after-end
  a_end_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_seen_q |-> byte_phase_i == PhEnd)
    else $error("byte after IEND not tagged as after-end");

endmodule

bind png_chunk_payload_xor_top pcpx_checker u_pcpx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .byte_phase_i  (out_o.byte_phase),
  .was_changed_i (out_o.was_changed)
);

>>> bench/png_chunk_payload_xor_top_tb.sv
// ----------------------------------------------------------------------------
// png_chunk_payload_xor_top_tb
// Self-checking bench for the PNG chunk walker with IDAT payload XOR.
// ----------------------------------------------------------------------------
// Streams one PNG file through the block: a directed opening with typed-in
// results, then random chunks (mostly IDAT, short payloads, one long one) with
// key changes over APB between chunks, then one terminal case. Reset happens
// once, so each run ends either in IEND or in the bad-length error, picked at
// random. The random part is checked against an in-bench chunk walker, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module png_chunk_payload_xor_top_tb;
  import pcpx_pkg::*;

  localparam int unsigned ItemsTarget  = 1850;
  localparam int unsigned CycleLimit   = 500_000;
  localparam int unsigned LatencyCycles = 4;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned HoldAfter    = 400;
  localparam int unsigned MaxPrinted   = 200;

  localparam logic [ApbAddrW-1:0] KeyAddr = {RegXorKey, 2'b00};

  localparam logic [7:0] PngMagic [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                          8'd13, 8'd10, 8'd26, 8'd10};

  typedef struct packed {
    logic [7:0] din;
    logic [7:0] dout;
    phase_e     ph;
    logic       flip;
  } row_t;

  // signature, then a 2-byte IDAT chunk with extreme payload bytes (reset key)
  localparam row_t DirRows [22] = '{
    '{8'd137, 8'd137, PhSig, 1'b0}, '{8'd80, 8'd80, PhSig, 1'b0},
    '{8'd78, 8'd78, PhSig, 1'b0},   '{8'd71, 8'd71, PhSig, 1'b0},
    '{8'd13, 8'd13, PhSig, 1'b0},   '{8'd10, 8'd10, PhSig, 1'b0},
    '{8'd26, 8'd26, PhSig, 1'b0},   '{8'd10, 8'd10, PhSig, 1'b0},
    '{8'h00, 8'h00, PhLen, 1'b0},   '{8'h00, 8'h00, PhLen, 1'b0},
    '{8'h00, 8'h00, PhLen, 1'b0},   '{8'h02, 8'h02, PhLen, 1'b0},
    '{8'h49, 8'h49, PhType, 1'b0},  '{8'h44, 8'h44, PhType, 1'b0},
    '{8'h41, 8'h41, PhType, 1'b0},  '{8'h54, 8'h54, PhType, 1'b0},
    '{8'hFF, 8'h17, PhData, 1'b1},  '{8'h00, 8'hE8, PhData, 1'b1},
    '{8'hA5, 8'hA5, PhCrc, 1'b0},   '{8'h5A, 8'h5A, PhCrc, 1'b0},
    '{8'hFF, 8'hFF, PhCrc, 1'b0},   '{8'h00, 8'h00, PhCrc, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  pcpx_in_if  in_ch ();
  pcpx_out_if out_ch ();

  png_chunk_payload_xor_top u_top (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // chunk walker state, mirrors the block from reset
  phase_e      pw_phase = PhSig;
  logic [30:0] pw_count = '0;
  logic [30:0] pw_len   = '0;
  logic [31:0] pw_type  = '0;
  logic [31:0] pw_shift = '0;
  logic [7:0]  cur_key  = KeyReset;

  entry_t      byte_queue [$];
  int unsigned fed_count      = 0;
  int unsigned got_count      = 0;
  int unsigned mismatch_count = 0;
  logic        out_hold       = 1'b0;

  function automatic entry_t walk_png_byte(input logic [7:0] b);
    entry_t r;
    r.data  = b;
    r.phase = pw_phase;
    r.flip  = 1'b0;
    case (pw_phase)
      PhSig: begin
        if (b != PngMagic[pw_count[2:0]]) begin
          pw_phase = PhErr;
          r.phase  = PhErr;
        end else if (pw_count >= 7) begin
          pw_count = '0;
          pw_shift = '0;
          pw_phase = PhLen;
        end else begin
          pw_count = pw_count + 1'b1;
        end
      end
      PhLen: begin
        if (pw_count == 0 && b[7]) begin
          pw_phase = PhErr;
          r.phase  = PhErr;
        end else begin
          pw_shift = {pw_shift[23:0], b};
          if (pw_count >= 3) begin
            pw_len   = pw_shift[30:0];
            pw_count = '0;
            pw_type  = '0;
            pw_phase = PhType;
          end else begin
            pw_count = pw_count + 1'b1;
          end
        end
      end
      PhType: begin
        pw_type = {pw_type[23:0], b};
        if (pw_count >= 3) begin
          pw_count = '0;
          if (pw_type == TypeIend) pw_phase = PhEnd;
          else if (pw_len == 0) pw_phase = PhCrc;
          else pw_phase = PhData;
        end else begin
          pw_count = pw_count + 1'b1;
        end
      end
      PhData: begin
        if (pw_type == TypeIdat) begin
          r.data = b ^ cur_key;
          r.flip = 1'b1;
        end
        pw_count = pw_count + 1'b1;
        if (pw_count >= pw_len) begin
          pw_count = '0;
          pw_phase = PhCrc;
        end
      end
      PhCrc: begin
        if (pw_count >= 3) begin
          pw_count = '0;
          pw_shift = '0;
          pw_phase = PhLen;
        end else begin
          pw_count = pw_count + 1'b1;
        end
      end
      PhErr: r.phase = PhErr;
      default: r.phase = PhEnd;
    endcase
    return r;
  endfunction

  // every fourth stretch of 128 transactions runs without idling
  function automatic int unsigned idle_cycles(input int unsigned n);
    if ((n / 128) % 4 == 1) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < MaxPrinted)
      $display("%0t mismatch %s: got %0h want %0h (result %0d)", $time, what, got, want,
               got_count);
    mismatch_count++;
  endtask

  // entered and left at a falling edge
  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= KeyAddr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_key(input logic [7:0] k);
    logic [31:0] rd;
    apb_xfer(1'b1, {24'd0, k}, rd);
    cur_key = k;
    apb_xfer(1'b0, '0, rd);
    if (rd[7:0] != k) flag_mismatch("key readback", rd, {24'd0, k});
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input entry_t want);
    int unsigned gap;
    entry_t      guess;
    gap = idle_cycles(fed_count);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    guess = walk_png_byte(b);
    byte_queue.push_back(typed ? want : guess);
    fed_count++;
    @(negedge clk);
  endtask

  task automatic send_chunk(input logic [31:0] clen, input logic [31:0] ctype);
    for (int i = 3; i >= 0; i--) send_byte(clen[8*i +: 8], 1'b0, '0);
    for (int i = 3; i >= 0; i--) send_byte(ctype[8*i +: 8], 1'b0, '0);
    repeat (clen) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // block is idle once every byte is back; the margin covers the pipeline
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (byte_queue.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : result_sink
    int unsigned gap;
    entry_t      want;
    gap = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else begin
        out_ch.ready <= !out_hold;
      end
      @(posedge clk);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got_count++;
        if (byte_queue.size() == 0) begin
          flag_mismatch("unexpected transaction", {24'd0, out_ch.out_byte}, '0);
        end else begin
          want = byte_queue.pop_front();
          if (out_ch.out_byte != want.data)
            flag_mismatch("out_byte", {24'd0, out_ch.out_byte}, {24'd0, want.data});
          if (out_ch.byte_phase != want.phase)
            flag_mismatch("byte_phase", {29'd0, out_ch.byte_phase}, {29'd0, want.phase});
          if (out_ch.was_changed != want.flip)
            flag_mismatch("was_changed", {31'd0, out_ch.was_changed}, {31'd0, want.flip});
        end
        gap = idle_cycles(got_count);
      end
    end
  end

  // long output stall while the sender keeps going, to back up the queue
  initial begin : output_hold
    wait (fed_count >= HoldAfter);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("FAIL png_chunk_payload_xor_top");
    $finish;
  end

  initial begin : stimulus
    row_t        row;
    entry_t      want;
    logic [31:0] clen;
    logic [31:0] ctype;
    logic [31:0] rd;
    int unsigned n_chunks;
    int unsigned pick;

    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    apb_xfer(1'b0, '0, rd);
    if (rd[7:0] != KeyReset) flag_mismatch("key after reset", rd, {24'd0, KeyReset});

    foreach (DirRows[i]) begin
      row        = DirRows[i];
      want.data  = row.dout;
      want.phase = row.ph;
      want.flip  = row.flip;
      send_byte(row.din, 1'b1, want);
    end

    n_chunks = 0;
    while (fed_count < ItemsTarget) begin
      if (n_chunks == 0) clen = 0;
      else if (n_chunks == 7) clen = 256 + $urandom_range(0, 40);
      else if ($urandom_range(0, 7) == 0) clen = 0;
      else clen = $urandom_range(1, 40);

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        ctype = TypeIdat;
      end else if (pick < 7) begin
        // near miss on the IDAT compare
        ctype = TypeIdat ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        ctype = $urandom;
        if (ctype == TypeIend) ctype = TypeIdat;
      end

      send_chunk(clen, ctype);
      n_chunks++;

      if (n_chunks % 12 == 0) begin
        wait_idle();
        case (n_chunks / 12)
          1: set_key(8'h00);
          2: set_key(8'hFF);
          default: set_key(8'($urandom_range(0, 255)));
        endcase
      end
    end

    // one terminal case per run: IEND with trailing bytes, or a bad length
    if ($urandom_range(0, 1) == 0) begin
      send_chunk($urandom_range(0, 6), TypeIend);
      repeat (20) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0, '0);
      repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (byte_queue.size() != 0) @(posedge clk);
    repeat (LatencyCycles * 2) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS png_chunk_payload_xor_top");
    end else begin
      $display("FAIL png_chunk_payload_xor_top");
    end
    $finish;
  end

endmodule
